// ===== rtl/dbpr_pkg.sv =====
// ---------------------------------------------------------------------------
// dbpr_pkg: shared types and constants for the dual band power ratio detector
// Widths of the sample, filter, energy and shared multiplier paths, and the
// register indexes and reset values of the configuration port.
// ---------------------------------------------------------------------------
package dbpr_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int FLEN_W   = 13;
    localparam int THR_W    = 16;
    localparam int FILT_W   = 24;
    localparam int ENERGY_W = 48;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // shared multiplier: signed operands, registered product
    localparam int MUL_W  = 25;
    localparam int PROD_W = 2 * MUL_W;

    // filter sum of products and its rounded, scaled form
    localparam int SUM_W   = 42;
    localparam int SHIFT_W = SUM_W - 14;

    // longest frame
    localparam int MAX_FRAME = 4096;

    typedef logic signed [MUL_W-1:0]  t_mul_op;
    typedef logic signed [PROD_W-1:0] t_prod;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_LENGTH    = 3'd0,
        CFG_RATIO_THRESHOLD = 3'd1,
        CFG_BAND_GAIN       = 3'd2,
        CFG_BAND_FB1        = 3'd3,
        CFG_BAND_FB2        = 3'd4,
        CFG_REF_GAIN        = 3'd5,
        CFG_REF_FB1         = 3'd6,
        CFG_REF_FB2         = 3'd7
    } t_cfg_idx;

    // register reset values
    localparam logic [FLEN_W-1:0]        RST_FRAME_LENGTH = 13'd1024;
    localparam logic [THR_W-1:0]         RST_THRESHOLD    = 16'd256;
    localparam logic signed [COEF_W-1:0] RST_BAND_GAIN    = 16'sd5644;
    localparam logic signed [COEF_W-1:0] RST_BAND_FB1     = 16'sd14373;
    localparam logic signed [COEF_W-1:0] RST_BAND_FB2     = 16'sd5096;
    localparam logic signed [COEF_W-1:0] RST_REF_GAIN     = 16'sd3660;
    localparam logic signed [COEF_W-1:0] RST_REF_FB1      = -16'sd23249;
    localparam logic signed [COEF_W-1:0] RST_REF_FB2      = 16'sd9065;

endpackage

// ===== rtl/dual_band_power_ratio_detector.sv =====
// ---------------------------------------------------------------------------
// dual_band_power_ratio_detector: two band-pass biquads with energy ratio test
// Filters each sample through a target and a reference band-pass biquad,
// sums the squared outputs over a frame with saturation and, at frame end,
// emits both energies and a flag set when target*256 >= threshold*reference.
//
//   channel   direction  word contents (lowest bit first)
//   s_axis    in         sample[15:0]
//   m_axis    out        detect[0], band_energy[48:1], ref_energy[96:49], zero pad
//   cfg       in         write enable, 3-bit register index, 16-bit data
//
// A sample passes from the accept state through states that issue the six
// filter products and two squares to the single shared multiplier, and an
// update state that takes the last square and advances the history. A sample
// that ends a frame goes on through states for the two threshold partial
// products and the compare, and waits there while an earlier result is still
// held in the output register.
// Reset is synchronous and active low; it restores the register defaults
// and clears filter history, energies and the sample count.
// ---------------------------------------------------------------------------
module dual_band_power_ratio_detector
    import dbpr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // sample[15:0]
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [103:0]         m_axis_tdata    // detect, band_energy, ref_energy, pad
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_BG,
        S_BF1,
        S_BF2,
        S_RG,
        S_RF1,
        S_RF2,
        S_SQB,
        S_SQR,
        S_UPD,
        S_THL,
        S_THH,
        S_CMP
    } t_state;

    t_state r_state;

    // configuration registers
    logic [FLEN_W-1:0]        r_frame_len;
    logic [THR_W-1:0]         r_thr;
    logic signed [COEF_W-1:0] r_band_gain, r_band_fb1, r_band_fb2;
    logic signed [COEF_W-1:0] r_ref_gain, r_ref_fb1, r_ref_fb2;

    // filter and frame state
    logic signed [SAMPLE_W-1:0] r_hist1, r_hist2, r_x;
    logic signed [SAMPLE_W:0]   r_diff;
    logic signed [FILT_W-1:0]   r_band_y1, r_band_y2, r_ref_y1, r_ref_y2;
    logic signed [FILT_W-1:0]   r_yb, r_yr;
    logic signed [SUM_W-1:0]    r_sum;
    logic [ENERGY_W-1:0]        r_band_acc, r_ref_acc;
    logic [FLEN_W-1:0]          r_count;
    logic [39:0]                r_lo;

    // output register
    logic                r_m_valid;
    logic                r_detect;
    logic [ENERGY_W-1:0] r_out_band, r_out_ref;

    // shared multiplier
    t_mul_op mul_a, mul_b;
    t_prod   prod;

    logic signed [SUM_W-1:0]    prod_sum;
    logic signed [SUM_W-1:0]    fin_sum;
    logic signed [FILT_W-1:0]   y_sat;
    logic [ENERGY_W-1:0]        acc_src;
    logic [ENERGY_W-1:0]        acc_sat;
    logic [ENERGY_W:0]          acc_wide;
    logic [FLEN_W-1:0]          frame_len_eff;
    logic [FLEN_W-1:0]          count_inc;
    logic                       frame_end;
    logic [63:0]                thr_ref;
    logic [63:0]                band_shift;
    logic                       out_free;
    logic signed [SAMPLE_W:0]   x_diff;

    // round by 2^-14 half up and saturate to the filter output range
    function automatic logic signed [FILT_W-1:0] round_sat(logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0]   t;
        logic signed [SHIFT_W-1:0] q;
        t = s + SUM_W'(8192);
        q = t[SUM_W-1:14];
        if (q[SHIFT_W-1] == 1'b0 && q[SHIFT_W-2:FILT_W-1] != '0) begin
            round_sat = {1'b0, {(FILT_W-1){1'b1}}};
        end else if (q[SHIFT_W-1] == 1'b1 && q[SHIFT_W-2:FILT_W-1] != '1) begin
            round_sat = {1'b1, {(FILT_W-1){1'b0}}};
        end else begin
            round_sat = q[FILT_W-1:0];
        end
    endfunction

    dbpr_mac u_mac (
        .i_clk  (i_clk),
        .i_op_a (mul_a),
        .i_op_b (mul_b),
        .o_prod (prod)
    );

    // select multiplier operands for the current step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_BG: begin
                mul_a = MUL_W'(r_band_gain);
                mul_b = MUL_W'(r_diff);
            end
            S_BF1: begin
                mul_a = MUL_W'(r_band_fb1);
                mul_b = MUL_W'(r_band_y1);
            end
            S_BF2: begin
                mul_a = MUL_W'(r_band_fb2);
                mul_b = MUL_W'(r_band_y2);
            end
            S_RG: begin
                mul_a = MUL_W'(r_ref_gain);
                mul_b = MUL_W'(r_diff);
            end
            S_RF1: begin
                mul_a = MUL_W'(r_ref_fb1);
                mul_b = MUL_W'(r_ref_y1);
            end
            S_RF2: begin
                mul_a = MUL_W'(r_ref_fb2);
                mul_b = MUL_W'(r_ref_y2);
            end
            S_SQB: begin
                mul_a = MUL_W'(r_yb);
                mul_b = MUL_W'(r_yb);
            end
            S_SQR: begin
                mul_a = MUL_W'(r_yr);
                mul_b = MUL_W'(r_yr);
            end
            S_THL: begin
                mul_a = {{(MUL_W-THR_W){1'b0}}, r_thr};
                mul_b = {1'b0, r_ref_acc[23:0]};
            end
            // hold the high partial product steady while the compare waits
            S_THH, S_CMP: begin
                mul_a = {{(MUL_W-THR_W){1'b0}}, r_thr};
                mul_b = {1'b0, r_ref_acc[47:24]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // filter sum, rounding and energy accumulation
    always_comb begin
        x_diff   = {s_axis_tdata[15], s_axis_tdata} - {r_hist2[SAMPLE_W-1], r_hist2};
        prod_sum = prod[SUM_W-1:0];
        fin_sum  = r_sum - prod_sum;
        y_sat    = round_sat(fin_sum);
        acc_src  = (r_state == S_SQR) ? r_band_acc : r_ref_acc;
        acc_wide = {1'b0, acc_src} + {1'b0, prod[ENERGY_W-1:0]};
        acc_sat  = acc_wide[ENERGY_W] ? {ENERGY_W{1'b1}} : acc_wide[ENERGY_W-1:0];
    end

    // frame length limits and frame end test
    always_comb begin
        if (r_frame_len == '0) begin
            frame_len_eff = FLEN_W'(1);
        end else if (r_frame_len > FLEN_W'(MAX_FRAME)) begin
            frame_len_eff = FLEN_W'(MAX_FRAME);
        end else begin
            frame_len_eff = r_frame_len;
        end
        count_inc = r_count + FLEN_W'(1);
        frame_end = (count_inc >= frame_len_eff);
    end

    // ratio test from the two threshold partial products
    always_comb begin
        thr_ref    = {prod[39:0], 24'd0} + {24'd0, r_lo};
        band_shift = {8'd0, r_band_acc, 8'd0};
        out_free   = !r_m_valid || m_axis_tready;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len <= RST_FRAME_LENGTH;
            r_thr       <= RST_THRESHOLD;
            r_band_gain <= RST_BAND_GAIN;
            r_band_fb1  <= RST_BAND_FB1;
            r_band_fb2  <= RST_BAND_FB2;
            r_ref_gain  <= RST_REF_GAIN;
            r_ref_fb1   <= RST_REF_FB1;
            r_ref_fb2   <= RST_REF_FB2;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_FRAME_LENGTH:    r_frame_len <= i_cfg_data[FLEN_W-1:0];
                CFG_RATIO_THRESHOLD: r_thr       <= i_cfg_data;
                CFG_BAND_GAIN:       r_band_gain <= i_cfg_data;
                CFG_BAND_FB1:        r_band_fb1  <= i_cfg_data;
                CFG_BAND_FB2:        r_band_fb2  <= i_cfg_data;
                CFG_REF_GAIN:        r_ref_gain  <= i_cfg_data;
                CFG_REF_FB1:         r_ref_fb1   <= i_cfg_data;
                CFG_REF_FB2:         r_ref_fb2   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sequencer, filter state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_hist1    <= '0;
            r_hist2    <= '0;
            r_band_y1  <= '0;
            r_band_y2  <= '0;
            r_ref_y1   <= '0;
            r_ref_y2   <= '0;
            r_band_acc <= '0;
            r_ref_acc  <= '0;
            r_count    <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            // drop the result once taken; in S_CMP the load below handles it
            if (m_axis_tready && r_state != S_CMP) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_x     <= s_axis_tdata;
                        r_diff  <= x_diff;
                        r_state <= S_BG;
                    end
                end
                S_BG: begin
                    r_state <= S_BF1;
                end
                S_BF1: begin
                    r_sum   <= prod_sum;
                    r_state <= S_BF2;
                end
                S_BF2: begin
                    r_sum   <= fin_sum;
                    r_state <= S_RG;
                end
                S_RG: begin
                    r_yb    <= y_sat;
                    r_state <= S_RF1;
                end
                S_RF1: begin
                    r_sum   <= prod_sum;
                    r_state <= S_RF2;
                end
                S_RF2: begin
                    r_sum   <= fin_sum;
                    r_state <= S_SQB;
                end
                S_SQB: begin
                    r_yr    <= y_sat;
                    r_state <= S_SQR;
                end
                S_SQR: begin
                    r_band_acc <= acc_sat;
                    r_state    <= S_UPD;
                end
                // advance history, add reference energy, check frame end
                S_UPD: begin
                    r_ref_acc <= acc_sat;
                    r_hist2   <= r_hist1;
                    r_hist1   <= r_x;
                    r_band_y2 <= r_band_y1;
                    r_band_y1 <= r_yb;
                    r_ref_y2  <= r_ref_y1;
                    r_ref_y1  <= r_yr;
                    if (frame_end) begin
                        r_count <= '0;
                        r_state <= S_THL;
                    end else begin
                        r_count <= count_inc;
                        r_state <= S_IDLE;
                    end
                end
                S_THL: begin
                    r_state <= S_THH;
                end
                S_THH: begin
                    r_lo    <= prod[39:0];
                    r_state <= S_CMP;
                end
                // load the result when the output register is free
                S_CMP: begin
                    if (out_free) begin
                        r_m_valid  <= 1'b1;
                        r_detect   <= (band_shift >= thr_ref);
                        r_out_band <= r_band_acc;
                        r_out_ref  <= r_ref_acc;
                        r_band_acc <= '0;
                        r_ref_acc  <= '0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {7'd0, r_out_ref, r_out_band, r_detect};

endmodule

// ===== rtl/dbpr_mac.sv =====
// ---------------------------------------------------------------------------
// dbpr_mac: shared signed multiplier
// One 25 x 25 signed multiply per cycle with the product registered.
// ---------------------------------------------------------------------------
module dbpr_mac
    import dbpr_pkg::*;
(
    input  logic    i_clk,
    input  t_mul_op i_op_a,
    input  t_mul_op i_op_b,
    output t_prod   o_prod
);

    t_prod r_prod;

    // register the product
    always_ff @(posedge i_clk) begin
        r_prod <= i_op_a * i_op_b;
    end

    assign o_prod = r_prod;

endmodule

// ===== bench/dual_band_power_ratio_detector_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dual_band_power_ratio_detector_tb: self-checking bench for the detector
// Streams signed samples into the block under random idling on both sides and
// predicts every frame result (detect flag, target and reference energies)
// with a cycle-free model of the two biquads and the saturating energy sums.
// Directed cases cover field extremes, filter and energy saturation, zero
// energies, short and oversized frame lengths and a frame length lowered
// mid-frame; random phases then vary all registers between idle points.
// ---------------------------------------------------------------------------
module dual_band_power_ratio_detector_tb;
    import dbpr_pkg::*;

    // expected frame result
    typedef struct {
        logic        detect;
        logic [47:0] band_energy;
        logic [47:0] ref_energy;
    } t_frame_result;

    // clock, reset and block ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata = '0;    // sample[15:0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [103:0]         m_axis_tdata;         // detect, band_energy, ref_energy, pad

    // register copies held by the predictor
    logic [12:0]        frame_len_reg;
    logic [15:0]        threshold_reg;
    logic signed [15:0] tgt_a0, tgt_b1, tgt_b2;
    logic signed [15:0] rfb_a0, rfb_b1, rfb_b2;

    // filter history, energy sums and frame position of the predictor
    logic signed [15:0] x_prev1, x_prev2;
    logic signed [23:0] tgt_y1, tgt_y2, rfb_y1, rfb_y2;
    logic [47:0]        tgt_energy, rfb_energy;
    logic [12:0]        frame_count;

    // stimulus and bookkeeping
    logic [15:0]   sample_backlog[$];
    t_frame_result pending_frames[$];
    int            samples_queued = 0;
    int            samples_taken = 0;
    int            frames_checked = 0;
    int            error_count = 0;
    int            sender_gap_pct = 36;
    int            sink_stall_pct = 36;
    int            random_items;
    int            frame_len;
    int            n_items;

    dual_band_power_ratio_detector uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // one biquad output: round half up after the Q2.14 scale, clamp to 24 bits
    function automatic logic signed [23:0] band_filter(longint x, longint x2, longint a0,
                                                       longint b1, longint b2,
                                                       longint y1, longint y2);
        longint sop;
        longint y;
        sop = a0 * (x - x2) - b1 * y1 - b2 * y2;
        y   = (sop + 64'sd8192) >>> 14;
        if (y > 64'sd8388607) y = 64'sd8388607;
        if (y < -64'sd8388608) y = -64'sd8388608;
        return y[23:0];
    endfunction

    // add one squared output to an energy sum, saturating at 48 bits
    function automatic logic [47:0] add_energy(logic [47:0] acc, logic signed [23:0] y);
        logic signed [63:0] yl;
        logic [63:0]        sq;
        logic [63:0]        sum;
        yl  = y;
        sq  = yl * yl;
        sum = {16'd0, acc} + sq;
        if (sum > 64'h0000_FFFF_FFFF_FFFF) sum = 64'h0000_FFFF_FFFF_FFFF;
        return sum[47:0];
    endfunction

    // restore register defaults and clear all predictor state
    function automatic void reset_predictor();
        frame_len_reg = RST_FRAME_LENGTH;
        threshold_reg = RST_THRESHOLD;
        tgt_a0 = RST_BAND_GAIN;
        tgt_b1 = RST_BAND_FB1;
        tgt_b2 = RST_BAND_FB2;
        rfb_a0 = RST_REF_GAIN;
        rfb_b1 = RST_REF_FB1;
        rfb_b2 = RST_REF_FB2;
        x_prev1 = '0;
        x_prev2 = '0;
        tgt_y1 = '0;
        tgt_y2 = '0;
        rfb_y1 = '0;
        rfb_y2 = '0;
        tgt_energy = '0;
        rfb_energy = '0;
        frame_count = '0;
    endfunction

    // advance the predictor by one accepted sample, queue a result at frame end
    function automatic void predict_sample(logic signed [15:0] x);
        logic signed [23:0] yt;
        logic signed [23:0] yr;
        logic [12:0]        len;
        logic [63:0]        lhs;
        logic [63:0]        rhs;
        t_frame_result      res;
        yt = band_filter(x, x_prev2, tgt_a0, tgt_b1, tgt_b2, tgt_y1, tgt_y2);
        yr = band_filter(x, x_prev2, rfb_a0, rfb_b1, rfb_b2, rfb_y1, rfb_y2);
        x_prev2 = x_prev1;
        x_prev1 = x;
        tgt_y2  = tgt_y1;
        tgt_y1  = yt;
        rfb_y2  = rfb_y1;
        rfb_y1  = yr;
        tgt_energy = add_energy(tgt_energy, yt);
        rfb_energy = add_energy(rfb_energy, yr);
        len = frame_len_reg;
        if (len == 0) len = 1;
        if (len > 13'(MAX_FRAME)) len = 13'(MAX_FRAME);
        frame_count = frame_count + 1'b1;
        if (frame_count >= len) begin
            lhs = {8'd0, tgt_energy, 8'd0};
            rhs = threshold_reg * rfb_energy;
            res.detect      = (lhs >= rhs);
            res.band_energy = tgt_energy;
            res.ref_energy  = rfb_energy;
            pending_frames.push_back(res);
            tgt_energy  = '0;
            rfb_energy  = '0;
            frame_count = '0;
        end
    endfunction

    // print one mismatch line and count it
    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        $display("%0t: frame %0d %s mismatch: got %0h, expected %0h",
                 $time, frames_checked, what, got, want);
        error_count++;
    endtask

    // write one register and mirror it in the predictor
    task automatic write_reg(t_cfg_idx idx, logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_FRAME_LENGTH:    frame_len_reg = value[12:0];
            CFG_RATIO_THRESHOLD: threshold_reg = value;
            CFG_BAND_GAIN:       tgt_a0 = value;
            CFG_BAND_FB1:        tgt_b1 = value;
            CFG_BAND_FB2:        tgt_b2 = value;
            CFG_REF_GAIN:        rfb_a0 = value;
            CFG_REF_FB1:         rfb_b1 = value;
            CFG_REF_FB2:         rfb_b2 = value;
            default: begin
            end
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_sample(logic [15:0] value);
        sample_backlog.push_back(value);
        samples_queued++;
    endtask

    // hold until every sample is taken and every result is back, then let the
    // block finish any sample that ends no frame
    task automatic wait_idle();
        while (samples_taken != samples_queued || pending_frames.size() != 0)
            @(posedge i_clk);
        repeat (32) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_sample();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return 16'($urandom);
        if (r < 85) return 16'($urandom_range(511)) - 16'd256;
        case ($urandom_range(2))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'h0000;
        endcase
    endfunction

    // filters near a nominal value, fully random ones, or extreme ones
    function automatic logic [15:0] pick_coef(logic [15:0] nominal);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40) return 16'($urandom);
        if (r < 80) return nominal + 16'($urandom_range(1023)) - 16'd512;
        case ($urandom_range(2))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'h0000;
        endcase
    endfunction

    function automatic logic [15:0] pick_threshold();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 35) return 16'($urandom);
        if (r < 85) return 16'($urandom_range(512, 128));
        return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endfunction

    function automatic int pick_frame_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(12, 1);
        if (r < 95) return $urandom_range(40, 13);
        return $urandom_range(1) ? 0 : $urandom_range(100, 41);
    endfunction

    // sample driver: predict on acceptance, load the next word or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_sample(s_axis_tdata);
                samples_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (sample_backlog.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= sample_backlog.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor: compare each accepted word with the oldest expectation
    always @(posedge i_clk) begin
        t_frame_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_frames.size() == 0) begin
                    report_mismatch("unexpected result, band_energy", m_axis_tdata[48:1], '0);
                end else begin
                    want = pending_frames.pop_front();
                    if (m_axis_tdata[0] !== want.detect)
                        report_mismatch("detect", 48'(m_axis_tdata[0]), 48'(want.detect));
                    if (m_axis_tdata[48:1] !== want.band_energy)
                        report_mismatch("band_energy", m_axis_tdata[48:1], want.band_energy);
                    if (m_axis_tdata[96:49] !== want.ref_energy)
                        report_mismatch("ref_energy", m_axis_tdata[96:49], want.ref_energy);
                end
                frames_checked++;
            end
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // hard stop for a hung block
    initial begin
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        reset_predictor();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero frame length acts as one: every sample ends a frame
        write_reg(CFG_FRAME_LENGTH, 16'd0);
        queue_sample(16'h7FFF);
        queue_sample(16'h8000);
        queue_sample(16'h0000);
        wait_idle();

        // runaway filters: outputs clamp and both energy sums saturate
        write_reg(CFG_FRAME_LENGTH, 16'd8);
        write_reg(CFG_RATIO_THRESHOLD, 16'hFFFF);
        write_reg(CFG_BAND_GAIN, 16'h8000);
        write_reg(CFG_BAND_FB1, 16'h8000);
        write_reg(CFG_BAND_FB2, 16'h7FFF);
        write_reg(CFG_REF_GAIN, 16'h7FFF);
        write_reg(CFG_REF_FB1, 16'h7FFF);
        write_reg(CFG_REF_FB2, 16'h8000);
        for (int i = 0; i < 8; i++) queue_sample((i % 2) ? 16'h8000 : 16'h7FFF);
        wait_idle();

        // all coefficients zero: both energies zero, detect must still be set
        write_reg(CFG_FRAME_LENGTH, 16'd2);
        write_reg(CFG_BAND_GAIN, 16'h0000);
        write_reg(CFG_BAND_FB1, 16'h0000);
        write_reg(CFG_BAND_FB2, 16'h0000);
        write_reg(CFG_REF_GAIN, 16'h0000);
        write_reg(CFG_REF_FB1, 16'h0000);
        write_reg(CFG_REF_FB2, 16'h0000);
        queue_sample(16'h7FFF);
        queue_sample(16'h8000);
        wait_idle();

        // frame length lowered below the count: next sample closes the frame
        write_reg(CFG_RATIO_THRESHOLD, RST_THRESHOLD);
        write_reg(CFG_BAND_GAIN, RST_BAND_GAIN);
        write_reg(CFG_BAND_FB1, RST_BAND_FB1);
        write_reg(CFG_BAND_FB2, RST_BAND_FB2);
        write_reg(CFG_REF_GAIN, RST_REF_GAIN);
        write_reg(CFG_REF_FB1, RST_REF_FB1);
        write_reg(CFG_REF_FB2, RST_REF_FB2);
        write_reg(CFG_FRAME_LENGTH, 16'd6);
        queue_sample(16'h1234);
        queue_sample(16'hEDCB);
        queue_sample(16'h4000);
        queue_sample(16'hC000);
        wait_idle();
        write_reg(CFG_FRAME_LENGTH, 16'd3);
        queue_sample(16'h0101);
        wait_idle();

        // oversized frame length clamps: no frame ends early, then a short
        // length closes the long frame; no idling here
        sender_gap_pct = 0;
        sink_stall_pct = 0;
        write_reg(CFG_FRAME_LENGTH, 16'hFFFF);
        for (int i = 0; i < 160; i++) queue_sample(pick_sample());
        wait_idle();
        write_reg(CFG_FRAME_LENGTH, 16'd3);
        queue_sample(pick_sample());
        wait_idle();
        sender_gap_pct = 36;
        sink_stall_pct = 36;

        // random phases: new settings at each idle point, partial frames carry over
        random_items = 0;
        while (random_items < 320) begin
            frame_len = pick_frame_len();
            write_reg(CFG_FRAME_LENGTH, 16'(frame_len));
            if ($urandom_range(1)) write_reg(CFG_RATIO_THRESHOLD, pick_threshold());
            if ($urandom_range(1)) write_reg(CFG_BAND_GAIN, pick_coef(RST_BAND_GAIN));
            if ($urandom_range(1)) write_reg(CFG_BAND_FB1, pick_coef(RST_BAND_FB1));
            if ($urandom_range(1)) write_reg(CFG_BAND_FB2, pick_coef(RST_BAND_FB2));
            if ($urandom_range(1)) write_reg(CFG_REF_GAIN, pick_coef(RST_REF_GAIN));
            if ($urandom_range(1)) write_reg(CFG_REF_FB1, pick_coef(RST_REF_FB1));
            if ($urandom_range(1)) write_reg(CFG_REF_FB2, pick_coef(RST_REF_FB2));
            if (frame_len == 0) frame_len = 1;
            n_items = frame_len * $urandom_range(4, 1);
            if ($urandom_range(3) == 0) n_items += $urandom_range(frame_len - 1);
            for (int i = 0; i < n_items; i++) queue_sample(pick_sample());
            random_items += n_items;
            wait_idle();
        end

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
